// ===== rtl/ptab_pkg.sv =====
// ----------------------------------------------------------------------------
// ptab_pkg: shared types and constants of the process key table
// table size, operation and status codes, scan result bundle, output helpers
// ----------------------------------------------------------------------------
package ptab_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [15:0] ROOT_LIMIT_RST = 16'd520;

  // operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  typedef enum logic [3:0] {
    STAT_ADDED     = 4'd0,
    STAT_UPDATED   = 4'd1,
    STAT_REMOVED   = 4'd2,
    STAT_HIT       = 4'd3,
    STAT_MISS      = 4'd4,
    STAT_ZERO_KEY  = 4'd5,
    STAT_EMPTY     = 4'd6,
    STAT_ROOT_LONG = 4'd7,
    STAT_FULL      = 4'd8
  } status_e;

  // outcome of one scan over the table
  typedef struct packed {
    logic             done;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             free_ok;
    logic [IDX_W-1:0] free_idx;
  } scan_res_t;

  // low four bits of a slot index
  function automatic logic [3:0] slot_bits(input logic [IDX_W-1:0] idx);
    logic [31:0] w;
    w = 32'(idx);
    return w[3:0];
  endfunction

  // entry count saturated to five bits
  function automatic logic [4:0] count_bits(input logic [CNT_W-1:0] cnt);
    logic [31:0] w;
    w = 32'(cnt);
    if (w > 32'd31) begin
      return 5'd31;
    end
    return w[4:0];
  endfunction

endpackage

// ===== rtl/ptab_scan.sv =====
// ----------------------------------------------------------------------------
// ptab_scan: slot scanner of the process key table
// walks the slots one per cycle with a single key comparator, records the
// lowest free slot scanned before any match and the lowest matching valid slot
// ----------------------------------------------------------------------------
module ptab_scan (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [31:0]                  key_i,
  input  logic [31:0]                  entry_key_i,
  input  logic                         entry_valid_i,
  output logic [ptab_pkg::IDX_W-1:0]   idx_o,
  output ptab_pkg::scan_res_t          res_o
);

  typedef enum logic {
    SC_IDLE,
    SC_RUN
  } scan_state_e;

  scan_state_e                 state_q;
  logic [ptab_pkg::IDX_W-1:0]  idx_q;
  ptab_pkg::scan_res_t         res_q;
  logic                        match;

  // the one shared comparator
  assign match = entry_valid_i && (entry_key_i == key_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      idx_q   <= '0;
      res_q   <= '0;
    end else begin
      case (state_q)
        SC_IDLE: begin
          res_q.done <= 1'b0;
          if (start_i) begin
            idx_q         <= '0;
            res_q.hit     <= 1'b0;
            res_q.free_ok <= 1'b0;
            state_q       <= SC_RUN;
          end
        end
        SC_RUN: begin
          if (!entry_valid_i && !res_q.free_ok) begin
            res_q.free_ok  <= 1'b1;
            res_q.free_idx <= idx_q;
          end
          if (match) begin
            res_q.hit     <= 1'b1;
            res_q.hit_idx <= idx_q;
            res_q.done    <= 1'b1;
            state_q       <= SC_IDLE;
          end else if (idx_q == ptab_pkg::LAST_IDX) begin
            res_q.done <= 1'b1;
            state_q    <= SC_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        default: begin
          state_q <= SC_IDLE;
        end
      endcase
    end
  end

  assign idx_o = idx_q;
  assign res_o = res_q;

endmodule

// ===== rtl/process_key_table.sv =====
// ----------------------------------------------------------------------------
// process_key_table: small keyed table of process entries
// add/update, remove, lookup and clear on a table of slots keyed by a
// process id, each slot holding a flags word and a root length
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------------
//  request  | in        | in_valid_i/in_stall_o   | op, key, flags_in, root_len_in
//  result   | out       | out_valid_o/out_stall_i | status, success, flags_out,
//           |           |                         | root_len_out, slot, entry_total
//  config   | in        | cfg_we_i (no wait)      | cfg_data_i -> root_limit
//
// - a request takes an accept step, then a scan of up to ENTRIES slots, a
//   step to hand the scan result over and a finish step; the scan stops at
//   the first hit
// - clear and rejected requests skip the scan and go from accept to finish
// - the rate is set by the slot scanner, which compares one slot per cycle
// - the result register parts the two sides: a new transaction is taken while
//   a finished result still waits; the finish cycle waits for a free result
//   register, so a stalled output holds the table unchanged
// - reset clears the valid bits and the count at once; root_limit resets to 520
//
module process_key_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] key_i,
  input  logic [31:0] flags_in_i,
  input  logic [15:0] root_len_in_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic        success_o,
  output logic [31:0] flags_out_o,
  output logic [15:0] root_len_out_o,
  output logic [3:0]  slot_o,
  output logic [4:0]  entry_total_o
);

  localparam int unsigned N  = ptab_pkg::ENTRIES;
  localparam int unsigned IW = ptab_pkg::IDX_W;
  localparam int unsigned CW = ptab_pkg::CNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_e;

  state_e state_q;

  // configuration register
  logic [15:0] root_limit_q;

  // table storage: valid bits and count are control, the rest is payload
  logic [N-1:0]  valid_q;
  logic [CW-1:0] count_q;
  logic [31:0]   entry_key_q   [N];
  logic [31:0]   entry_flags_q [N];
  logic [15:0]   entry_rlen_q  [N];

  // captured request
  logic [1:0]  op_q;
  logic [31:0] key_q;
  logic [31:0] flags_q;
  logic [15:0] rlen_q;

  // result register
  logic        out_valid_q;
  logic [3:0]  status_q;
  logic        success_q;
  logic [31:0] flags_out_q;
  logic [15:0] rlen_out_q;
  logic [3:0]  slot_q;
  logic [4:0]  count_out_q;

  // scanner
  logic                scan_start;
  logic [IW-1:0]       scan_idx;
  ptab_pkg::scan_res_t scan_res;

  // request accept and the early decision on whether a scan is needed
  logic in_accept;
  logic need_scan;
  logic fire;

  // finish-cycle decisions
  ptab_pkg::status_e fin_status;
  logic [IW-1:0]     fin_idx;
  logic              fin_touch;
  logic              wr_data;
  logic              wr_new;
  logic              clr_one;
  logic              clr_all;
  logic [31:0]       fin_flags;
  logic [15:0]       fin_rlen;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // zero key, empty root and long root are settled without a scan
  assign need_scan = (op_i != ptab_pkg::OP_CLEAR) && (key_i != 32'd0) &&
                     ((op_i != ptab_pkg::OP_ADD) ||
                      ((root_len_in_i != 16'd0) && (root_len_in_i <= root_limit_q)));

  assign scan_start = in_accept && need_scan;

  ptab_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (scan_start),
    .key_i         (key_q),
    .entry_key_i   (entry_key_q[scan_idx]),
    .entry_valid_i (valid_q[scan_idx]),
    .idx_o         (scan_idx),
    .res_o         (scan_res)
  );

  // result is loaded when the result register is free or being emptied
  assign fire = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    fin_status = ptab_pkg::STAT_MISS;
    fin_idx    = '0;
    fin_touch  = 1'b0;
    wr_data    = 1'b0;
    wr_new     = 1'b0;
    clr_one    = 1'b0;
    clr_all    = 1'b0;
    fin_flags  = 32'd0;
    fin_rlen   = 16'd0;
    if (op_q == ptab_pkg::OP_CLEAR) begin
      clr_all    = 1'b1;
      fin_status = ptab_pkg::STAT_REMOVED;
    end else if (key_q == 32'd0) begin
      fin_status = ptab_pkg::STAT_ZERO_KEY;
    end else begin
      case (op_q)
        ptab_pkg::OP_ADD: begin
          if (rlen_q == 16'd0) begin
            fin_status = ptab_pkg::STAT_EMPTY;
          end else if (rlen_q > root_limit_q) begin
            fin_status = ptab_pkg::STAT_ROOT_LONG;
          end else if (scan_res.hit) begin
            // existing entry: new flags and root length
            fin_status = ptab_pkg::STAT_UPDATED;
            fin_idx    = scan_res.hit_idx;
            fin_touch  = 1'b1;
            wr_data    = 1'b1;
          end else if (scan_res.free_ok) begin
            // lowest free slot takes the new entry
            fin_status = ptab_pkg::STAT_ADDED;
            fin_idx    = scan_res.free_idx;
            fin_touch  = 1'b1;
            wr_data    = 1'b1;
            wr_new     = 1'b1;
          end else begin
            fin_status = ptab_pkg::STAT_FULL;
          end
        end
        ptab_pkg::OP_REMOVE: begin
          if (scan_res.hit) begin
            fin_status = ptab_pkg::STAT_REMOVED;
            fin_idx    = scan_res.hit_idx;
            fin_touch  = 1'b1;
            clr_one    = 1'b1;
          end
        end
        default: begin
          // lookup
          if (scan_res.hit) begin
            fin_status = ptab_pkg::STAT_HIT;
            fin_idx    = scan_res.hit_idx;
            fin_touch  = 1'b1;
            fin_flags  = entry_flags_q[scan_res.hit_idx];
            fin_rlen   = entry_rlen_q[scan_res.hit_idx];
          end
        end
      endcase
    end
  end

  // table payload writes, only on the finish cycle
  always_ff @(posedge clk_i) begin
    if (fire && wr_data) begin
      entry_flags_q[fin_idx] <= flags_q;
      entry_rlen_q[fin_idx]  <= rlen_q;
    end
    if (fire && wr_new) begin
      entry_key_q[fin_idx] <= key_q;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q    <= op_i;
      key_q   <= key_i;
      flags_q <= flags_in_i;
      rlen_q  <= root_len_in_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q    <= fin_status;
      success_q   <= (fin_status <= ptab_pkg::STAT_HIT);
      flags_out_q <= fin_flags;
      rlen_out_q  <= fin_rlen;
      slot_q      <= fin_touch ? ptab_pkg::slot_bits(fin_idx) : 4'd0;
      if (clr_all) begin
        count_out_q <= 5'd0;
      end else if (wr_new) begin
        count_out_q <= ptab_pkg::count_bits(count_q + 1'b1);
      end else if (clr_one && (count_q != '0)) begin
        count_out_q <= ptab_pkg::count_bits(count_q - 1'b1);
      end else begin
        count_out_q <= ptab_pkg::count_bits(count_q);
      end
    end
  end

  // sequencer, valid bits, count, config and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      root_limit_q <= ptab_pkg::ROOT_LIMIT_RST;
      valid_q      <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        root_limit_q <= cfg_data_i;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            state_q <= need_scan ? S_SCAN : S_FIN;
          end
        end
        S_SCAN: begin
          if (scan_res.done) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (fire) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
            if (clr_all) begin
              valid_q <= '0;
              count_q <= '0;
            end else if (wr_new) begin
              valid_q[fin_idx] <= 1'b1;
              count_q          <= count_q + 1'b1;
            end else if (clr_one) begin
              valid_q[fin_idx] <= 1'b0;
              if (count_q != '0) begin
                count_q <= count_q - 1'b1;
              end
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign success_o      = success_q;
  assign flags_out_o    = flags_out_q;
  assign root_len_out_o = rlen_out_q;
  assign slot_o         = slot_q;
  assign entry_total_o  = count_out_q;

  // count tracks the valid bits
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == $countones(valid_q))
    else $error("entry count differs from number of valid slots");

  // scanner finishes only while the sequencer waits for it
  a_scan_done_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_res.done |-> (state_q == S_SCAN))
    else $error("scan completed outside of scan state");

  // a new entry always lands in a free slot
  a_add_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && wr_new) |-> !valid_q[fin_idx])
    else $error("add wrote into an occupied slot");

  // a result appears only out of the finish step
  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result valid raised outside finish step");

  // remove and lookup hits report the scanned slot
  a_hit_is_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (clr_one || (fin_status == ptab_pkg::STAT_HIT))) |-> valid_q[fin_idx])
    else $error("hit reported on an invalid slot");

endmodule
